### src/pti_pkg.sv
`timescale 1ns / 1ps
package pti_pkg;

	localparam int MAX_POINTS_DEF = 256;

	localparam int TIME_W  = 32;
	localparam int VAL_W   = 32;
	localparam int QT_W    = 48;
	localparam int PC_W    = 9;
	localparam int LIDX_W  = 8;
	localparam int SEG_W   = 8;
	localparam int CYC_W   = 16;
	localparam int FRAC_W  = 17;
	localparam int FRAC_SH = 16;
	localparam int DIV_STEPS = FRAC_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [CYC_W-1:0] CYC_MAX   = '1;
	localparam logic [CYC_W-1:0] CYC_RESET = CYC_W'(1);
	localparam logic [PC_W-1:0]  PC_RESET  = PC_W'(2);

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [PADDR_W-3:0] REG_POINT_COUNT = '0;

	typedef struct packed {
		logic [TIME_W-1:0] t;
		logic [VAL_W-1:0]  p;
		logic [VAL_W-1:0]  e;
	} point_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOCAL,
		ST_WRAP,
		ST_CHECK,
		ST_SCAN,
		ST_RD_LO,
		ST_RD_HI,
		ST_CAP_HI,
		ST_PREP,
		ST_CLAMP,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		RD_LAST,
		RD_ZERO,
		RD_NEXT,
		RD_LO,
		RD_HI
	} rd_sel_t;

	typedef struct packed {
		logic    capture;
		logic    local_calc;
		logic    wrap;
		logic    check;
		logic    scan;
		logic    cap_lo;
		logic    cap_hi;
		logic    prep;
		logic    clamp;
		logic    div_step;
		logic    mul;
		logic    sum;
		logic    out_load;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic beyond;
		logic scan_stop;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

### src/pti_item_if.sv
`timescale 1ns / 1ps
interface pti_item_if;
	logic                          valid;
	logic                          ready;
	logic                          op;
	logic [pti_pkg::LIDX_W-1:0]    load_index;
	logic [pti_pkg::TIME_W-1:0]    point_time;
	logic [pti_pkg::VAL_W-1:0]     point_pressure;
	logic [pti_pkg::VAL_W-1:0]     point_entropy;
	logic [pti_pkg::QT_W-1:0]      query_time;

	modport source (
		output valid, op, load_index, point_time, point_pressure, point_entropy, query_time,
		input  ready
	);
	modport sink (
		input  valid, op, load_index, point_time, point_pressure, point_entropy, query_time,
		output ready
	);
endinterface

### src/pti_result_if.sv
`timescale 1ns / 1ps
interface pti_result_if;
	logic                         valid;
	logic                         ready;
	logic [pti_pkg::VAL_W-1:0]    pressure_out;
	logic [pti_pkg::VAL_W-1:0]    entropy_out;
	logic [pti_pkg::SEG_W-1:0]    segment_index;
	logic [pti_pkg::CYC_W-1:0]    cycle_number;
	logic                         cycle_started;
	logic                         beyond_table;

	modport source (
		output valid, pressure_out, entropy_out, segment_index, cycle_number,
		       cycle_started, beyond_table,
		input  ready
	);
	modport sink (
		input  valid, pressure_out, entropy_out, segment_index, cycle_number,
		       cycle_started, beyond_table,
		output ready
	);
endinterface

### src/pti_controller.sv
`timescale 1ns / 1ps
module pti_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_op,
	output logic              item_ready,
	input  pti_pkg::status_t  status,
	output pti_pkg::cmd_t     cmd
);
	import pti_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = RD_LAST;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d = (item_op == OP_LOAD) ? ST_OUT : ST_LOCAL;
				end
			end
			ST_LOCAL: begin
				cmd.local_calc = 1'b1;
				cmd.rd_sel = RD_LAST;
				state_d = ST_WRAP;
			end
			ST_WRAP: begin
				cmd.wrap = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				cmd.rd_sel = RD_ZERO;
				state_d = status.beyond ? ST_OUT : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				cmd.rd_sel = RD_NEXT;
				if (status.scan_stop) state_d = ST_RD_LO;
			end
			ST_RD_LO: begin
				cmd.rd_sel = RD_LO;
				state_d = ST_RD_HI;
			end
			ST_RD_HI: begin
				cmd.rd_sel = RD_HI;
				cmd.cap_lo = 1'b1;
				state_d = ST_CAP_HI;
			end
			ST_CAP_HI: begin
				cmd.cap_hi = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### src/pti_datapath.sv
`timescale 1ns / 1ps
module pti_datapath #(
	parameter int MAX_POINTS = pti_pkg::MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pti_pkg::cmd_t                 cmd,
	output pti_pkg::status_t              status,
	input  logic [pti_pkg::PC_W-1:0]      point_count,
	input  logic                          item_op,
	input  logic [pti_pkg::LIDX_W-1:0]    load_index,
	input  logic [pti_pkg::TIME_W-1:0]    point_time,
	input  logic [pti_pkg::VAL_W-1:0]     point_pressure,
	input  logic [pti_pkg::VAL_W-1:0]     point_entropy,
	input  logic [pti_pkg::QT_W-1:0]      query_time,
	pti_result_if.source                  result
);
	import pti_pkg::*;

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int NW  = (AW + 1 > PC_W) ? AW + 1 : PC_W;
	localparam int DCW = $clog2(DIV_STEPS);
	localparam int PW  = VAL_W + FRAC_W + 2;

	// points in use, clamped to 2..MAX_POINTS
	logic [NW-1:0] pc_ext, n_use;
	logic [AW-1:0] last;

	assign pc_ext = NW'(point_count);

	always_comb begin
		priority if (pc_ext < NW'(2)) begin
			n_use = NW'(2);
		end else if (pc_ext > NW'(MAX_POINTS)) begin
			n_use = NW'(MAX_POINTS);
		end else begin
			n_use = pc_ext;
		end
	end

	assign last = AW'(n_use - NW'(1));

	// table memory
	point_t        mem [MAX_POINTS];
	point_t        rdata_q;
	logic [AW-1:0] rd_addr;
	logic          wr_en;

	logic [AW-1:0] scan_q, seg_q;

	assign wr_en = cmd.capture && (item_op == OP_LOAD) &&
		(32'(load_index) < 32'(MAX_POINTS));

	always_comb begin
		unique case (cmd.rd_sel)
			RD_LAST: rd_addr = last;
			RD_ZERO: rd_addr = '0;
			RD_NEXT: rd_addr = scan_q + AW'(1);
			RD_LO:   rd_addr = seg_q - AW'(1);
			RD_HI:   rd_addr = seg_q;
			default: rd_addr = last;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(load_index)] <= '{t: point_time, p: point_pressure, e: point_entropy};
		end
		rdata_q <= mem[rd_addr];
	end

	// working registers
	logic [QT_W-1:0]   qt_q, local_q, num_q;
	logic [QT_W-1:0]   base_q;
	logic [CYC_W-1:0]  cyc_q;
	logic [TIME_W-1:0] period_q, den_q;
	logic [VAL_W-1:0]  plast_q, elast_q;
	point_t            lo_q, hi_q;
	logic              fzero_q;
	logic [TIME_W:0]   rem_q;
	logic [FRAC_W-1:0] quot_q;
	logic [DCW-1:0]    dcnt_q;
	logic signed [VAL_W:0]  dp_q, de_q;
	logic signed [PW-1:0]   prod_p_q, prod_e_q;
	logic [VAL_W-1:0]  res_p_q, res_e_q;
	logic [SEG_W-1:0]  res_seg_q;
	logic              started_q, beyond_q;
	logic              out_valid_q;

	logic [QT_W-1:0]   period_w;
	logic              wrap_gt;
	logic              div_ge;
	logic [TIME_W:0]   rem_sub;
	logic [FRAC_W-1:0] frac;
	logic signed [FRAC_W:0] frac_s;
	logic signed [PW-1:0]   sum_p, sum_e;

	assign period_w = QT_W'(rdata_q.t);
	assign wrap_gt  = local_q > period_w;

	assign div_ge  = rem_q >= {1'b0, den_q};
	assign rem_sub = div_ge ? (rem_q - {1'b0, den_q}) : rem_q;

	assign frac   = fzero_q ? '0 : quot_q;
	assign frac_s = $signed({1'b0, frac});

	assign sum_p = $signed({{(PW-VAL_W){1'b0}}, lo_q.p}) + (prod_p_q >>> FRAC_SH);
	assign sum_e = $signed({{(PW-VAL_W){1'b0}}, lo_q.e}) + (prod_e_q >>> FRAC_SH);

	assign status.beyond    = local_q > QT_W'(period_q);
	assign status.scan_stop = (scan_q == last) || !(QT_W'(rdata_q.t) < local_q);
	assign status.div_last  = dcnt_q == DCW'(DIV_STEPS - 1);
	assign status.out_free  = !out_valid_q || result.ready;

	// cycle state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyc_q       <= CYC_RESET;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wrap && wrap_gt) begin
				if (cyc_q != CYC_MAX) cyc_q <= cyc_q + CYC_W'(1);
				base_q <= base_q + period_w;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			qt_q      <= query_time;
			res_p_q   <= '0;
			res_e_q   <= '0;
			res_seg_q <= '0;
			started_q <= 1'b0;
			beyond_q  <= 1'b0;
		end
		if (cmd.local_calc) begin
			local_q <= (qt_q >= base_q) ? (qt_q - base_q) : '0;
		end
		if (cmd.wrap) begin
			period_q <= rdata_q.t;
			plast_q  <= rdata_q.p;
			elast_q  <= rdata_q.e;
			if (wrap_gt) begin
				local_q   <= local_q - period_w;
				started_q <= 1'b1;
			end
		end
		if (cmd.check) begin
			scan_q <= '0;
			if (status.beyond) begin
				res_p_q   <= plast_q;
				res_e_q   <= elast_q;
				res_seg_q <= SEG_W'(last);
				beyond_q  <= 1'b1;
			end
		end
		if (cmd.scan) begin
			if (status.scan_stop) begin
				seg_q <= (scan_q == '0) ? AW'(1) : scan_q;
			end else begin
				scan_q <= scan_q + AW'(1);
			end
		end
		if (cmd.cap_lo) lo_q <= rdata_q;
		if (cmd.cap_hi) hi_q <= rdata_q;
		if (cmd.prep) begin
			den_q   <= hi_q.t - lo_q.t;
			fzero_q <= hi_q.t <= lo_q.t;
			num_q   <= (local_q > QT_W'(lo_q.t)) ? (local_q - QT_W'(lo_q.t)) : '0;
		end
		if (cmd.clamp) begin
			rem_q     <= (num_q > QT_W'(den_q)) ? {1'b0, den_q} : {1'b0, num_q[TIME_W-1:0]};
			quot_q    <= '0;
			dcnt_q    <= '0;
			dp_q      <= $signed({1'b0, hi_q.p}) - $signed({1'b0, lo_q.p});
			de_q      <= $signed({1'b0, hi_q.e}) - $signed({1'b0, lo_q.e});
			res_seg_q <= SEG_W'(seg_q);
		end
		if (cmd.div_step) begin
			rem_q  <= {rem_sub[TIME_W-1:0], 1'b0};
			quot_q <= {quot_q[FRAC_W-2:0], div_ge};
			dcnt_q <= dcnt_q + DCW'(1);
		end
		if (cmd.mul) begin
			prod_p_q <= PW'(dp_q * frac_s);
			prod_e_q <= PW'(de_q * frac_s);
		end
		if (cmd.sum) begin
			res_p_q <= sum_p[VAL_W-1:0];
			res_e_q <= sum_e[VAL_W-1:0];
		end
		if (cmd.out_load) begin
			result.pressure_out  <= res_p_q;
			result.entropy_out   <= res_e_q;
			result.segment_index <= res_seg_q;
			result.cycle_number  <= cyc_q;
			result.cycle_started <= started_q;
			result.beyond_table  <= beyond_q;
		end
	end

	assign result.valid = out_valid_q;

endmodule

### src/periodic_table_interpolator.sv
`timescale 1ns / 1ps
// channel   | dir | handshake          | payload
// item      | in  | valid/ready        | op, load_index, point_time/pressure/entropy, query_time
// result    | out | valid/ready        | pressure_out, entropy_out, segment_index, cycle_number,
//           |     |                    | cycle_started, beyond_table
// apb       | in  | psel/penable/pwrite| paddr, pwdata -> point_count; prdata readback
//
// A load goes straight to the output state. A query past the table end skips the scan. For other
// queries the scan reads one table entry per cycle from the table memory, then a radix-2
// divider forms the fraction.
// One transaction in flight; the result register holds a finished result while the
// next item is taken. Reset (arst_n) resets control and cycle state; the table is not cleared.
module periodic_table_interpolator #(
	parameter int MAX_POINTS = pti_pkg::MAX_POINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	pti_item_if.sink                       item,
	pti_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pti_pkg::PADDR_W-1:0]    paddr,
	input  logic [pti_pkg::PDATA_W-1:0]    pwdata,
	output logic [pti_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);
	import pti_pkg::*;

	logic [PC_W-1:0] point_count_q;
	logic            cfg_wr;
	logic            reg_hit;
	cmd_t            cmd;
	status_t         status;
	logic            ctl_ready;

	assign pready  = 1'b1;
	assign reg_hit = paddr[PADDR_W-1:2] == REG_POINT_COUNT;
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? PDATA_W'(point_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= PC_RESET;
		end else if (cfg_wr) begin
			point_count_q <= pwdata[PC_W-1:0];
		end
	end

	assign item.ready = ctl_ready;

	pti_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_op    (item.op),
		.item_ready (ctl_ready),
		.status     (status),
		.cmd        (cmd)
	);

	pti_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.point_count    (point_count_q),
		.item_op        (item.op),
		.load_index     (item.load_index),
		.point_time     (item.point_time),
		.point_pressure (item.point_pressure),
		.point_entropy  (item.point_entropy),
		.query_time     (item.query_time),
		.result         (result)
	);

`ifndef SYNTHESIS
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item accepted while another is in flight");

	a_beyond_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.beyond_table |-> result.cycle_started)
		else $error("beyond_table without a new cycle");

	a_cycle_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.cycle_number != '0)
		else $error("cycle count reached zero");
`endif

endmodule
